### rtl/core/split_link_set_into_two_paths_macros.svh
// Assertion macros for the two-path link splitter.
// Included by the top level; depends on nothing else.
`ifndef SPLIT_LINK_SET_INTO_TWO_PATHS_MACROS_SVH
`define SPLIT_LINK_SET_INTO_TWO_PATHS_MACROS_SVH

`ifndef ASSERT_OFF
// Antecedent and consequent in the same cycle.
`define SLSTP_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Consequent in the cycle after the antecedent.
`define SLSTP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define SLSTP_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define SLSTP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### rtl/core/slstp_pkg.sv
// Shared types and constants of the two-path link splitter.
// Used by the controller, the datapath and the top level; depends on nothing.
package slstp_pkg;

    localparam int NODE_W = 10;

    typedef struct packed {
        logic [NODE_W-1:0] flow_source;
        logic [NODE_W-1:0] flow_dest;
        logic [NODE_W-1:0] link_from;
        logic [NODE_W-1:0] link_to;
        logic              end_of_group;
    } t_in_word;

    typedef struct packed {
        logic              path_kind;
        logic [NODE_W-1:0] out_source;
        logic [NODE_W-1:0] out_dest;
        logic [NODE_W-1:0] hop_from;
        logic [NODE_W-1:0] hop_to;
        logic              last;
    } t_out_word;

    localparam logic KIND_PRIMARY = 1'b0;
    localparam logic KIND_BACKUP  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store;
        logic walk_init;
        logic take;
        logic step;
        logic next_walk;
        logic flush;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic scan_end;
        logic at_dest;
        logic kind;
    } t_stat;

endpackage

### rtl/core/slstp_ctrl.sv
// Controller state machine of the two-path link splitter.
// Depends on slstp_pkg for the command and status types.
module slstp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_eog,
    input  slstp_pkg::t_stat i_stat,
    output slstp_pkg::t_cmd  o_cmd,
    output logic             o_busy
);
    import slstp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   walk_done;

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        walk_done = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.store = 1'b1;
                    if (i_eog) begin
                        o_cmd.walk_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    o_cmd.take = 1'b1;
                    walk_done  = i_stat.at_dest;
                end else if (i_stat.scan_end) begin
                    walk_done = 1'b1;
                end else begin
                    o_cmd.step = 1'b1;
                end
                if (walk_done) begin
                    if (i_stat.kind == KIND_BACKUP) begin
                        n_state = S_FLUSH;
                    end else begin
                        o_cmd.next_walk = 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### rtl/core/slstp_dpath.sv
// Datapath of the two-path link splitter: link table, scan pointer, result staging.
// Depends on slstp_pkg for the word, command and status types.
module slstp_dpath #(
    parameter int MAX_LINKS = 32,
    parameter int NODE_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  slstp_pkg::t_in_word  i_word,
    input  slstp_pkg::t_cmd      i_cmd,
    output slstp_pkg::t_stat     o_stat,
    output logic                 o_strobe,
    output slstp_pkg::t_out_word o_word
);
    import slstp_pkg::*;

    localparam int IW = $clog2(MAX_LINKS);
    localparam int CW = $clog2(MAX_LINKS + 1);
    localparam int WB = (NODE_BITS > NODE_W) ? NODE_BITS : NODE_W;

    typedef logic [NODE_BITS-1:0] t_node;
    typedef logic [WB-1:0]        t_wide;

    t_node           r_from [MAX_LINKS];
    t_node           r_to   [MAX_LINKS];
    logic [MAX_LINKS-1:0] r_used;

    logic [CW-1:0] r_count, n_count;
    t_node         r_src, n_src;
    t_node         r_dst, n_dst;
    logic          r_forbid_v, n_forbid_v;
    t_node         r_forbid, n_forbid;
    logic [IW-1:0] r_j, n_j;
    t_node         r_node, n_node;
    logic          r_kind, n_kind;
    logic          r_first, n_first;
    t_out_word     r_pend, n_pend;
    logic          r_pend_v, n_pend_v;
    t_out_word     r_out, n_out;
    logic          r_out_v, n_out_v;

    t_node in_src;
    t_node in_dst;
    t_node in_from;
    t_node in_to;
    t_node e_from;
    t_node e_to;
    logic  e_used;
    t_node cur;
    logic  forbid_hit;
    logic  can_store;

    assign in_src  = t_node'(t_wide'(i_word.flow_source));
    assign in_dst  = t_node'(t_wide'(i_word.flow_dest));
    assign in_from = t_node'(t_wide'(i_word.link_from));
    assign in_to   = t_node'(t_wide'(i_word.link_to));

    assign e_from = r_from[r_j];
    assign e_to   = r_to[r_j];
    assign e_used = r_used[r_j];

    // The first hop of a walk leaves the flow source, later hops the current node.
    assign cur        = r_first ? r_src : r_node;
    assign forbid_hit = r_first && (r_kind == KIND_BACKUP) && r_forbid_v && (e_to == r_forbid);
    assign can_store  = (r_count < CW'(MAX_LINKS));

    assign o_stat.hit      = !e_used && (e_from == cur) && !forbid_hit;
    assign o_stat.scan_end = ((CW'(r_j) + CW'(1)) == r_count);
    assign o_stat.at_dest  = (e_to == r_dst);
    assign o_stat.kind     = r_kind;

    always_comb begin
        n_count    = r_count;
        n_src      = r_src;
        n_dst      = r_dst;
        n_forbid_v = r_forbid_v;
        n_forbid   = r_forbid;
        n_j        = r_j;
        n_node     = r_node;
        n_kind     = r_kind;
        n_first    = r_first;
        n_pend     = r_pend;
        n_pend_v   = r_pend_v;
        n_out      = r_out;
        n_out_v    = 1'b0;

        if (i_cmd.store) begin
            if (r_count == '0) begin
                n_src = in_src;
                n_dst = in_dst;
            end
            if (can_store) begin
                n_count = r_count + CW'(1);
            end
        end

        if (i_cmd.walk_init) begin
            n_forbid_v = 1'b0;
            n_kind     = KIND_PRIMARY;
            n_first    = 1'b1;
            n_j        = '0;
        end

        if (i_cmd.step) begin
            n_j = r_j + IW'(1);
        end

        if (i_cmd.take) begin
            if (r_first && (r_kind == KIND_PRIMARY)) begin
                n_forbid_v = 1'b1;
                n_forbid   = e_to;
            end
            n_node  = e_to;
            n_first = 1'b0;
            n_j     = '0;
            // The staged result goes out now; the new one waits to learn if it is last.
            n_out      = r_pend;
            n_out_v    = r_pend_v;
            n_pend     = '{path_kind:  r_kind,
                           out_source: NODE_W'(t_wide'(r_src)),
                           out_dest:   NODE_W'(t_wide'(r_dst)),
                           hop_from:   NODE_W'(t_wide'(e_from)),
                           hop_to:     NODE_W'(t_wide'(e_to)),
                           last:       1'b0};
            n_pend_v   = 1'b1;
        end

        if (i_cmd.next_walk) begin
            n_kind  = KIND_BACKUP;
            n_first = 1'b1;
            n_j     = '0;
        end

        if (i_cmd.flush) begin
            n_out      = r_pend;
            n_out.last = 1'b1;
            n_out_v    = r_pend_v;
            n_pend_v   = 1'b0;
            n_count    = '0;
            n_forbid_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_src      <= '0;
            r_dst      <= '0;
            r_forbid_v <= 1'b0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
            r_kind     <= KIND_PRIMARY;
            r_first    <= 1'b1;
            r_j        <= '0;
        end else begin
            r_count    <= n_count;
            r_src      <= n_src;
            r_dst      <= n_dst;
            r_forbid_v <= n_forbid_v;
            r_pend_v   <= n_pend_v;
            r_out_v    <= n_out_v;
            r_kind     <= n_kind;
            r_first    <= n_first;
            r_j        <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        r_forbid <= n_forbid;
        r_node   <= n_node;
        r_pend   <= n_pend;
        r_out    <= n_out;
        if (i_cmd.store && can_store) begin
            r_from[r_count[IW-1:0]] <= in_from;
            r_to[r_count[IW-1:0]]   <= in_to;
            r_used[r_count[IW-1:0]] <= 1'b0;
        end
        if (i_cmd.take) begin
            r_used[r_j] <= 1'b1;
        end
    end

    assign o_strobe = r_out_v;
    assign o_word   = r_out;

endmodule

### rtl/core/split_link_set_into_two_paths.sv
// Top level of the two-path link splitter: controller, datapath and checks.
// Depends on slstp_pkg, slstp_ctrl, slstp_dpath and the assertion macro header.
//
// The block collects the hop links of one flow, one word per accepted start, and
// when a word carries end_of_group it walks the stored links twice: first the
// primary path from the flow source, then a backup path whose first hop may not
// end where the primary's first hop ended. Each walk stops at the flow destination
// or when no unused link leaves the current node. Result words come out in path
// order, one per o_strobe pulse, and the last word of a group has last set; the
// receiver cannot stall, so every strobed word must be taken in its cycle. A word
// without end_of_group is only stored, and busy stays low. At group end busy
// rises: the link table has one read port and is scanned one entry per cycle from
// entry 0 for every hop; after the walks a release step hands out the final word.
// The final result word shows in the cycle after that release step, as busy
// falls; a group that finds no path gives no result word at all. Links beyond
// MAX_LINKS in a group are dropped, and the flow source and destination of a
// group come from its first word.
module split_link_set_into_two_paths #(
    parameter int MAX_LINKS = 32,
    parameter int NODE_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  slstp_pkg::t_in_word  i_word,
    output logic                 o_strobe,
    output slstp_pkg::t_out_word o_word
);
    import slstp_pkg::*;

    `include "split_link_set_into_two_paths_macros.svh"

    t_cmd  cmd;
    t_stat stat;

    // The controller sequences storing, scanning and the final release.
    slstp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_eog   (i_word.end_of_group),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // The datapath holds the table, the scan pointer and the result staging.
    slstp_dpath #(
        .MAX_LINKS (MAX_LINKS),
        .NODE_BITS (NODE_BITS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_word   (i_word),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_word   (o_word)
    );

    // Results only appear while a group is being walked or right after it.
    `SLSTP_ASSERT_SAME(a_strobe_from_walk, i_clk, i_rst_n, o_strobe, $past(busy), "result outside a walk")
    // Nothing follows the last word of a group in the next cycle.
    `SLSTP_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_strobe && o_word.last, !o_strobe, "result after last")
    // The release step always hands the block back to idle.
    `SLSTP_ASSERT_NEXT(a_flush_idle, i_clk, i_rst_n, cmd.flush, !busy, "busy after release")
    // A link is only taken when the datapath reports a matching entry.
    `SLSTP_ASSERT_SAME(a_take_hit, i_clk, i_rst_n, cmd.take, stat.hit && busy, "take without hit")

endmodule
